/* rtl/sfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_pkg: shared constants and types for the single-precision multiplier.
// Field positions of the single-precision format and the split of the
// mantissa into high and low parts.
// ----------------------------------------------------------------------------
package sfm_pkg;
    localparam int unsigned FRAC_W  = 23;
    localparam int unsigned EXP_W   = 8;
    localparam int unsigned LO_W    = 11;
    localparam int unsigned HI_W    = 13;
    localparam int unsigned EST_W   = 26;
    localparam logic [EXP_W:0] EXP_BIAS = 9'd127;
    localparam logic [EST_W-1:0] EST_ADD = 26'd2;

    typedef logic [31:0] word_t;
endpackage

/* rtl/sfm_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_core: product arithmetic.
// Combinational sign, exponent and truncated mantissa estimate from two
// registered operands.
// ----------------------------------------------------------------------------
module sfm_core
(
    input  sfm_pkg::word_t a,
    input  sfm_pkg::word_t b,
    output sfm_pkg::word_t p
);
    import sfm_pkg::*;

    logic [HI_W-1:0]  hia, hib;
    logic [LO_W-1:0]  loa, lob;
    logic [2*HI_W-1:0] hh;
    logic [HI_W+LO_W-1:0] hl, lh;
    logic [EST_W-1:0] est;
    logic             carry;
    logic [FRAC_W-1:0] frac;
    logic [EXP_W-1:0]  expo;

    // Split each mantissa with its hidden one.
    assign hia = {1'b1, a[FRAC_W-1:LO_W]};
    assign hib = {1'b1, b[FRAC_W-1:LO_W]};
    assign loa = a[LO_W-1:0];
    assign lob = b[LO_W-1:0];

    // Partial products; the low-times-low term is dropped.
    assign hh  = hia * hib;
    assign hl  = hia * lob;
    assign lh  = hib * loa;
    assign est = hh + EST_W'(hl >> LO_W) + EST_W'(lh >> LO_W) + EST_ADD;

    // Normalise: the leading one is at bit 24 or bit 25.
    assign carry = est[EST_W-1];
    assign frac  = carry ? est[EST_W-2:EST_W-1-FRAC_W] : est[EST_W-3:EST_W-2-FRAC_W];
    assign expo  = EXP_W'({1'b0, a[30:23]} + {1'b0, b[30:23]} - EXP_BIAS
                          + {{EXP_W{1'b0}}, carry});

    assign p = {a[31] ^ b[31], expo, frac};
endmodule

/* rtl/single_float_multiplier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_float_multiplier: approximate single-precision multiply.
// Truncated mantissa, wrapping exponent, no special-value handling.
// ----------------------------------------------------------------------------
// Usage:
// A request carries operand_a and operand_b and is taken on a rising edge
// with in_valid high and in_stall low. Each request yields one product on
// the output channel, taken when out_valid is high and out_stall low.
// The operands are registered, the arithmetic sits between that register
// and the result register, and out_valid is driven by the result register.
// One request is accepted every cycle while in_stall is low; each of the two
// register stages is free whenever it is empty or the one after it moves.
// When the receiver stalls the product holds and the pipeline fills;
// in_stall rises only once both stages hold items.
// Reset clears both valid flags; no request is lost or repeated.
// ----------------------------------------------------------------------------
module single_float_multiplier
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sfm_pkg::word_t operand_a,
    input  sfm_pkg::word_t operand_b,
    output logic           out_valid,
    input  logic           out_stall,
    output sfm_pkg::word_t product
);
    import sfm_pkg::*;

    logic  a_valid_reg, p_valid_reg;
    word_t a_reg, b_reg, p_reg, p_next;
    logic  adv_p, adv_a;

    // Stage enables.
    assign adv_p    = !p_valid_reg || !out_stall;
    assign adv_a    = !a_valid_reg || adv_p;
    assign in_stall = !adv_a;

    sfm_core u_core (.a(a_reg), .b(b_reg), .p(p_next));

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                a_valid_reg <= in_valid;
            if (adv_p)
                p_valid_reg <= a_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (adv_p && a_valid_reg)
            p_reg <= p_next;
    end

    assign out_valid = p_valid_reg;
    assign product   = p_reg;

    // A stalled product must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product))
        else $error("product changed under stall");

    // Input is stalled only when both stages are full.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg && p_valid_reg && out_stall)
        else $error("input stalled with free stage");

    // An accepted request reaches the output stage next cycle when free.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && adv_p |=> p_valid_reg)
        else $error("request lost between stages");
endmodule
